FILE: design/rrpf_pkg.sv
// Package for the rounded rectangle premultiplied fill block.
// Holds field widths, configuration register indexes and beat/config structs.
// No dependencies.
package rrpf_pkg;

    localparam int DIM_W      = 13;
    localparam int RAD_W      = 12;
    localparam int POS_W      = 12;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int SQ_W       = 2 * DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BLUE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ALPHA   = 3'd6;

    typedef struct packed {
        logic [POS_W-1:0] pixel_col;
        logic [POS_W-1:0] pixel_row;
    } t_pixel_in;

    typedef struct packed {
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_alpha;
        logic            inside_shape;
    } t_pixel_out;

    typedef struct packed {
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
        logic [RAD_W-1:0] corner_radius;
    } t_geom_cfg;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_color;

    typedef struct packed {
        logic vld;
        logic hit;
    } t_geom_res;

endpackage

FILE: design/rrpf_premul.sv
// Premultiplies the fill color by alpha: (c*a+127)/255 per channel.
// Two register stages, multiply then divide by 255. Depends on rrpf_pkg.
module rrpf_premul
    import rrpf_pkg::*;
(
    input  logic   i_clk,
    input  t_color i_color,
    output t_color o_color
);

    localparam int P_W = 2 * CH_W;

    logic [P_W-1:0] r_pr, r_pg, r_pb;
    logic [CH_W-1:0] r_a0;
    t_color r_out;

    logic [P_W-1:0] n_pr, n_pg, n_pb;

    function automatic logic [CH_W-1:0] div255(input logic [P_W-1:0] p);
        logic [P_W:0] s;
        s = {1'b0, p} + (P_W+1)'(p >> CH_W) + (P_W+1)'(1);
        return s[P_W-1:CH_W];
    endfunction

    always_comb begin
        n_pr = P_W'(i_color.red)   * P_W'(i_color.alpha) + P_W'(127);
        n_pg = P_W'(i_color.green) * P_W'(i_color.alpha) + P_W'(127);
        n_pb = P_W'(i_color.blue)  * P_W'(i_color.alpha) + P_W'(127);
    end

    always_ff @(posedge i_clk) begin
        r_pr <= n_pr;
        r_pg <= n_pg;
        r_pb <= n_pb;
        r_a0 <= i_color.alpha;
        r_out.red   <= div255(r_pr);
        r_out.green <= div255(r_pg);
        r_out.blue  <= div255(r_pb);
        r_out.alpha <= r_a0;
    end

    assign o_color = r_out;

endmodule

FILE: design/rrpf_geom.sv
// Six-stage corner test pipeline in doubled pixel coordinates.
// Clamp, offsets, corner distances, squares, compare. Depends on rrpf_pkg.
module rrpf_geom
    import rrpf_pkg::*;
#(
    parameter int MAX_DIM = 4096
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    input  t_pixel_in i_pixel,
    input  t_geom_cfg i_cfg,
    output t_geom_res o_res
);

    localparam int STAGES  = 6;
    localparam int DimMax  = (1 << DIM_W) - 1;
    localparam int CapInt  = (MAX_DIM > DimMax) ? DimMax : MAX_DIM;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(CapInt);

    logic [STAGES-1:0] r_vld;

    // stage A
    logic [POS_W-1:0] r_a_col, r_a_row;
    logic [DIM_W-1:0] r_a_w, r_a_h, r_a_r2raw;
    // stage B
    logic [DIM_W-1:0] r_b_x, r_b_y, r_b_r2;
    logic [DIM_W:0]   r_b_w2, r_b_h2;
    logic             r_b_rng;
    // stage C
    logic [DIM_W-1:0] r_c_x, r_c_y, r_c_r2;
    logic [DIM_W:0]   r_c_xe, r_c_ye;
    logic             r_c_rng;
    // stage D
    logic [DIM_W-1:0] r_d_dx, r_d_dy, r_d_r2;
    logic             r_d_zone, r_d_rng;
    // stage E
    logic [SQ_W-1:0]  r_e_dx2, r_e_dy2, r_e_rr;
    logic             r_e_zone, r_e_rng;
    // stage F
    logic             r_f_inside;

    logic [DIM_W-1:0] n_a_w, n_a_h, n_b_m, n_b_r2;
    logic             n_xlo, n_xhi, n_ylo, n_yhi;
    logic [DIM_W-1:0] n_dx, n_dy;
    logic [SQ_W:0]    n_sum;

    always_comb begin
        n_a_w = (i_cfg.rect_width  > DIM_CAP) ? DIM_CAP : i_cfg.rect_width;
        n_a_h = (i_cfg.rect_height > DIM_CAP) ? DIM_CAP : i_cfg.rect_height;
        n_b_m  = (r_a_w < r_a_h) ? r_a_w : r_a_h;
        n_b_r2 = (r_a_r2raw < n_b_m) ? r_a_r2raw : n_b_m;
        n_xlo = r_c_x < r_c_r2;
        n_ylo = r_c_y < r_c_r2;
        n_xhi = {1'b0, r_c_x} > r_c_xe;
        n_yhi = {1'b0, r_c_y} > r_c_ye;
        n_dx  = n_xlo ? (r_c_r2 - r_c_x) : DIM_W'({1'b0, r_c_x} - r_c_xe);
        n_dy  = n_ylo ? (r_c_r2 - r_c_y) : DIM_W'({1'b0, r_c_y} - r_c_ye);
        n_sum = {1'b0, r_e_dx2} + {1'b0, r_e_dy2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_col   <= i_pixel.pixel_col;
        r_a_row   <= i_pixel.pixel_row;
        r_a_w     <= n_a_w;
        r_a_h     <= n_a_h;
        r_a_r2raw <= {i_cfg.corner_radius, 1'b0};

        r_b_x   <= {r_a_col, 1'b1};
        r_b_y   <= {r_a_row, 1'b1};
        r_b_r2  <= n_b_r2;
        r_b_w2  <= {r_a_w, 1'b0};
        r_b_h2  <= {r_a_h, 1'b0};
        r_b_rng <= ({1'b0, r_a_col} < r_a_w) && ({1'b0, r_a_row} < r_a_h);

        r_c_x   <= r_b_x;
        r_c_y   <= r_b_y;
        r_c_r2  <= r_b_r2;
        r_c_xe  <= r_b_w2 - {1'b0, r_b_r2};
        r_c_ye  <= r_b_h2 - {1'b0, r_b_r2};
        r_c_rng <= r_b_rng;

        r_d_dx   <= n_dx;
        r_d_dy   <= n_dy;
        r_d_r2   <= r_c_r2;
        r_d_zone <= (n_xlo || n_xhi) && (n_ylo || n_yhi);
        r_d_rng  <= r_c_rng;

        r_e_dx2  <= SQ_W'(r_d_dx) * SQ_W'(r_d_dx);
        r_e_dy2  <= SQ_W'(r_d_dy) * SQ_W'(r_d_dy);
        r_e_rr   <= SQ_W'(r_d_r2) * SQ_W'(r_d_r2);
        r_e_zone <= r_d_zone;
        r_e_rng  <= r_d_rng;

        r_f_inside <= r_e_rng && (!r_e_zone || (n_sum <= {1'b0, r_e_rr}));
    end

    assign o_res.vld = r_vld[STAGES-1];
    assign o_res.hit = r_f_inside;

endmodule

FILE: design/rounded_rect_premultiplied_fill.sv
// Top level of the rounded rectangle premultiplied fill block.
// Config registers, geometry pipeline, premultiply unit and result register.
// Depends on rrpf_pkg, rrpf_geom, rrpf_premul.
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------
//  pixel in  | start / busy        | i_pixel   (t_pixel_in)
//  result    | o_strobe            | o_result  (t_pixel_out)
//  config    | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One beat in per clock; busy stays low. Each result is registered after its
// start beat passes the six geometry stages and then the result register.
// Reset clears the stage valid bits and the config registers to their
// defaults; the strobe is one cycle wide and cannot be held off.
module rounded_rect_premultiplied_fill
    import rrpf_pkg::*;
#(
    parameter int MAX_DIM = 4096
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_pixel_in             i_pixel,
    output logic                  o_strobe,
    output t_pixel_out            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_geom_cfg  r_geom_cfg;
    t_color     r_color;
    t_color     w_premul;
    t_geom_res  w_res;
    logic       r_strobe;
    t_pixel_out r_out;
    t_pixel_out n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom_cfg.rect_width    <= DIM_W'(1);
            r_geom_cfg.rect_height   <= DIM_W'(1);
            r_geom_cfg.corner_radius <= '0;
            r_color.red              <= '0;
            r_color.green            <= '0;
            r_color.blue             <= '0;
            r_color.alpha            <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RECT_WIDTH:    r_geom_cfg.rect_width    <= i_cfg_data;
                CFG_RECT_HEIGHT:   r_geom_cfg.rect_height   <= i_cfg_data;
                CFG_CORNER_RADIUS: r_geom_cfg.corner_radius <= i_cfg_data[RAD_W-1:0];
                CFG_COLOR_RED:     r_color.red              <= i_cfg_data[CH_W-1:0];
                CFG_COLOR_GREEN:   r_color.green            <= i_cfg_data[CH_W-1:0];
                CFG_COLOR_BLUE:    r_color.blue             <= i_cfg_data[CH_W-1:0];
                CFG_COLOR_ALPHA:   r_color.alpha            <= i_cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    rrpf_geom #(
        .MAX_DIM (MAX_DIM)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_pixel (i_pixel),
        .i_cfg   (r_geom_cfg),
        .o_res   (w_res)
    );

    rrpf_premul u_premul (
        .i_clk   (i_clk),
        .i_color (r_color),
        .o_color (w_premul)
    );

    always_comb begin
        n_out = '0;
        if (w_res.hit) begin
            n_out.out_blue     = w_premul.blue;
            n_out.out_green    = w_premul.green;
            n_out.out_red      = w_premul.red;
            n_out.out_alpha    = w_premul.alpha;
            n_out.inside_shape = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

FILE: design/rrpf_checker.sv
// Port-level checks for rounded_rect_premultiplied_fill, bound to the top.
// Depends on rrpf_pkg.
module rrpf_checker
    import rrpf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_strobe,
    input t_pixel_out            o_result
);

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_strobe)
        else $error("accepted beat produced no result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##7 !o_strobe)
        else $error("result without accepted beat");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.inside_shape) |->
        (o_result.out_blue == '0 && o_result.out_green == '0 &&
         o_result.out_red == '0 && o_result.out_alpha == '0))
        else $error("nonzero color outside shape");

    a_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.out_alpha == '0) |->
        (o_result.out_blue == '0 && o_result.out_green == '0 &&
         o_result.out_red == '0))
        else $error("color with zero alpha");

endmodule

bind rounded_rect_premultiplied_fill rrpf_checker u_rrpf_checker (.*);
